// ===== rtl/core/ndd_pkg.sv =====
// ndd_pkg: shared types, codes and fixed-point helpers for the newton interpolator
// depends on nothing; imported by newton_divided_difference_interp
package ndd_pkg;

    localparam logic       REQ_LOAD = 1'b0;
    localparam logic       REQ_EVAL = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DIV0 = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    // magnitude of a signed word; the most negative value maps to 2^31
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    // clamp a 33-bit difference into 32 bits
    function automatic sat_t sat33(input logic signed [32:0] v);
        sat_t r;
        r.clip = v[32] != v[31];
        if (!r.clip)
        begin
            r.val = v[31:0];
        end
        else
        begin
            r.val = v[32] ? Q_MIN : Q_MAX;
        end
        sat33 = r;
    endfunction

    // rebuild a signed word from magnitude and sign with clamping
    function automatic sat_t from_mag(input logic [63:0] m, input logic neg);
        sat_t r;
        r.clip = 1'b0;
        if (neg)
        begin
            if (m > 64'h8000_0000)
            begin
                r.clip = 1'b1;
                r.val  = Q_MIN;
            end
            else
            begin
                r.val = -m[31:0];
            end
        end
        else
        begin
            if (m > 64'h7FFF_FFFF)
            begin
                r.clip = 1'b1;
                r.val  = Q_MAX;
            end
            else
            begin
                r.val = m[31:0];
            end
        end
        from_mag = r;
    endfunction

endpackage

// ===== rtl/core/ndd_if.sv =====
// ndd_if: request and response channel interfaces for the newton interpolator
// depends on nothing; valid/ready handshake with source and sink modports
interface ndd_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [3:0]         point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;

    modport source (output valid, req_type, point_index, x_value, y_value, input ready);
    modport sink   (input valid, req_type, point_index, x_value, y_value, output ready);
endinterface

interface ndd_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== rtl/core/ndd_ram.sv =====
// ndd_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module ndd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ndd_div.sv =====
// ndd_div: unsigned restoring divider, one quotient bit per cycle
// depends on nothing; 33-bit divisor, NUM_W-bit dividend and quotient
module ndd_div #(
    parameter int NUM_W = 49
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [32:0]      den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [32:0]      rem_reg, rem_next;
    logic [NUM_W-1:0] shn_reg, shn_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [32:0]      den_reg, den_next;
    logic [33:0]      trial;
    logic             fit;

    assign trial = {rem_reg, shn_reg[NUM_W-1]};
    assign fit   = trial >= {1'b0, den_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        shn_next    = shn_reg;
        q_next      = q_reg;
        den_next    = den_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(NUM_W);
            rem_next    = '0;
            shn_next    = num;
            q_next      = '0;
            den_next    = den;
        end
        else if (active_reg)
        begin
            rem_next = fit ? 33'(trial - {1'b0, den_reg}) : trial[32:0];
            shn_next = shn_reg << 1;
            q_next   = {q_reg[NUM_W-2:0], fit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shn_reg <= shn_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== rtl/core/newton_divided_difference_interp.sv =====
// newton_divided_difference_interp: top level of the newton interpolator
// depends on ndd_pkg, ndd_if, ndd_ram and ndd_div
//
// usage
//   req channel (ndd_req_if sink): a load request (req_type 0) writes node x and
//   value y into slot point_index; an evaluate request (req_type 1) asks for the
//   polynomial value at query x_value. every request gets one response.
//   rsp channel (ndd_rsp_if source): result_value and status (ok, duplicate
//   nodes, saturated). loads answer zero with status ok.
//   cfg_wr_en/cfg_wr_data write points_in_use; write only while idle.
// flow
//   one request at a time; ready is high only while the sequencer is idle.
//   load: the response is staged in res_reg, then in the response register.
//   evaluate with fresh coefficients: one read-multiply-normalize pass
//   through the node ram per factor.
//   the first evaluate after a load or register write first rebuilds the
//   coefficients: a copy of the node values, then one divided-difference
//   step per table entry, each a divide on the bit-serial divider.
// reset clears control state: coefficients stale, no fault, points_in_use 5.
// a stalled response waits in the output register; the next request is still
// taken and its response waits until the register frees up.
module newton_divided_difference_interp
    import ndd_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ndd_req_if.sink    req,
    ndd_rsp_if.source  rsp,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int NUM_W = 33 + FRAC_BITS;
    localparam int ACC_W = 33 + $clog2(MAX_POINTS);

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_CP_RD  = 15'b000000000000010,
        ST_CP_WR  = 15'b000000000000100,
        ST_RB_A   = 15'b000000000001000,
        ST_RB_B   = 15'b000000000010000,
        ST_RB_C   = 15'b000000000100000,
        ST_RB_DIV = 15'b000000001000000,
        ST_EV_C0  = 15'b000000010000000,
        ST_EV_A0  = 15'b000000100000000,
        ST_EV_CI  = 15'b000001000000000,
        ST_EV_T   = 15'b000010000000000,
        ST_EV_X   = 15'b000100000000000,
        ST_EV_D   = 15'b001000000000000,
        ST_EV_MUL = 15'b010000000000000,
        ST_EV_NRM = 15'b100000000000000
    } state_t;

    // final-sum and response staging both run in ST_IDLE, tracked by fin_reg and this phase
    typedef enum logic [1:0] {
        PH_WORK = 2'b01,
        PH_DONE = 2'b10
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic               fin_reg, fin_next;
    logic               stale_reg, stale_next;
    logic               fault_reg, fault_next;
    logic               clip_reg, clip_next;
    logic [4:0]         pts_reg, pts_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      u_reg, u_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic signed [31:0] qx_reg, qx_next;
    logic signed [31:0] c_hi_reg, c_hi_next;
    logic signed [31:0] x_hi_reg, x_hi_next;
    logic signed [31:0] term_reg, term_next;
    logic signed [31:0] d_reg, d_next;
    logic               neg_reg, neg_next;
    logic [63:0]        prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic signed [31:0] res_reg, res_next;
    logic [1:0]         stat_reg, stat_next;
    logic signed [31:0] rsp_val_reg, rsp_val_next;
    logic [1:0]         rsp_stat_reg, rsp_stat_next;

    logic [CW-1:0]      n_act;
    logic               accept;
    logic               n_we;
    logic [AW-1:0]      n_waddr, n_raddr;
    logic [31:0]        x_rdata, y_rdata;
    logic               c_we;
    logic [AW-1:0]      c_waddr, c_raddr;
    logic [31:0]        c_wdata, c_rdata;
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_quo;
    logic [32:0]        div_den;
    logic signed [32:0] dx, dy;
    logic [CW-1:0]      u_minus_i, u_minus_1;
    sat_t               dsat, fm, qd;
    logic               acc_fits;

    // active point count, clamped to the legal range
    always_comb
    begin
        if (pts_reg < 5'd2)
        begin
            n_act = CW'(2);
        end
        else if (32'(pts_reg) > MAX_POINTS)
        begin
            n_act = CW'(MAX_POINTS);
        end
        else
        begin
            n_act = CW'(pts_reg);
        end
    end

    assign req.ready = (state_reg == ST_IDLE) && (phase_reg == PH_WORK) && !fin_reg;
    assign accept    = req.valid && req.ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_val_reg;
    assign rsp.status       = rsp_stat_reg;

    // node tables are written only by load requests
    assign n_we    = accept && (req.req_type == REQ_LOAD) && (32'(req.point_index) < MAX_POINTS);
    assign n_waddr = AW'(req.point_index);

    assign u_minus_i = u_reg - i_reg;
    assign u_minus_1 = u_reg - CW'(1);

    assign dx = 33'(x_hi_reg) - 33'(signed'(x_rdata));
    assign dy = 33'(c_hi_reg) - 33'(signed'(c_rdata));

    assign div_num   = {mag33(dy), {FRAC_BITS{1'b0}}};
    assign div_den   = mag33(dx);
    assign div_start = (state_reg == ST_RB_C) && (dx != '0);

    assign qd       = from_mag(64'(div_quo), neg_reg);
    assign dsat     = sat33(33'(qx_reg) - 33'(signed'(x_rdata)));
    assign fm       = from_mag(prod_reg >> FRAC_BITS, neg_reg);
    assign acc_fits = (&acc_reg[ACC_W-1:31]) || !(|acc_reg[ACC_W-1:31]);

    // ram addressing by sequencer state
    always_comb
    begin
        n_raddr = u_reg[AW-1:0];
        c_raddr = u_reg[AW-1:0];
        case (state_reg)
            ST_RB_B:  begin
                n_raddr = u_minus_i[AW-1:0];
                c_raddr = u_minus_1[AW-1:0];
            end
            ST_EV_C0: c_raddr = '0;
            ST_EV_CI: c_raddr = i_reg[AW-1:0];
            default:  ;
        endcase
    end

    always_comb
    begin
        c_we    = 1'b0;
        c_waddr = u_reg[AW-1:0];
        c_wdata = y_rdata;
        case (state_reg)
            ST_CP_WR:  c_we = 1'b1;
            ST_RB_C:
            begin
                if (dx == '0)
                begin
                    c_we    = 1'b1;
                    c_wdata = '0;
                end
            end
            ST_RB_DIV:
            begin
                c_we    = div_done;
                c_wdata = qd.val;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        fin_next       = fin_reg;
        stale_next     = stale_reg;
        fault_next     = fault_reg;
        clip_next      = clip_reg;
        pts_next       = pts_reg;
        i_next         = i_reg;
        u_next         = u_reg;
        rsp_valid_next = rsp_valid_reg;
        qx_next        = qx_reg;
        c_hi_next      = c_hi_reg;
        x_hi_next      = x_hi_reg;
        term_next      = term_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        rsp_val_next   = rsp_val_reg;
        rsp_stat_next  = rsp_stat_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (fin_reg)
                begin
                    // clamp the running sum into the result word
                    fin_next   = 1'b0;
                    phase_next = PH_DONE;
                    res_next   = acc_fits ? acc_reg[31:0]
                                          : (acc_reg[ACC_W-1] ? Q_MIN : Q_MAX);
                    stat_next  = (sat_reg || !acc_fits || clip_reg) ? STAT_SAT : STAT_OK;
                end
                else if (phase_reg == PH_DONE)
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_val_next   = res_reg;
                        rsp_stat_next  = stat_reg;
                        phase_next     = PH_WORK;
                    end
                end
                else if (accept)
                begin
                    if (req.req_type == REQ_LOAD)
                    begin
                        stale_next = 1'b1;
                        res_next   = '0;
                        stat_next  = STAT_OK;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        qx_next = req.x_value;
                        if (stale_reg)
                        begin
                            fault_next = 1'b0;
                            clip_next  = 1'b0;
                            u_next     = '0;
                            state_next = ST_CP_RD;
                        end
                        else
                        begin
                            state_next = ST_EV_C0;
                        end
                    end
                end
            end
            // copy node values into the coefficient table
            ST_CP_RD: state_next = ST_CP_WR;
            ST_CP_WR:
            begin
                if (u_reg == n_act - CW'(1))
                begin
                    i_next     = CW'(1);
                    state_next = ST_RB_A;
                end
                else
                begin
                    u_next     = u_reg + CW'(1);
                    state_next = ST_CP_RD;
                end
            end
            // one divided-difference step per column entry, top down
            ST_RB_A: state_next = ST_RB_B;
            ST_RB_B:
            begin
                c_hi_next  = c_rdata;
                x_hi_next  = x_rdata;
                state_next = ST_RB_C;
            end
            ST_RB_C, ST_RB_DIV:
            begin
                if (state_reg == ST_RB_C)
                begin
                    neg_next = dx[32] != dy[32];
                end
                if ((state_reg == ST_RB_C && dx == '0) || (state_reg == ST_RB_DIV && div_done))
                begin
                    if (state_reg == ST_RB_C)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        clip_next = clip_reg || qd.clip;
                    end
                    if (u_reg == i_reg)
                    begin
                        if (i_reg == n_act - CW'(1))
                        begin
                            stale_next = 1'b0;
                            state_next = ST_EV_C0;
                        end
                        else
                        begin
                            i_next     = i_reg + CW'(1);
                            u_next     = n_act - CW'(1);
                            state_next = ST_RB_A;
                        end
                    end
                    else
                    begin
                        u_next     = u_reg - CW'(1);
                        state_next = ST_RB_A;
                    end
                end
                else if (state_reg == ST_RB_C)
                begin
                    state_next = ST_RB_DIV;
                end
            end
            ST_EV_C0:
            begin
                if (fault_reg)
                begin
                    res_next   = '0;
                    stat_next  = STAT_DIV0;
                    phase_next = PH_DONE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EV_A0;
                end
            end
            ST_EV_A0:
            begin
                acc_next   = ACC_W'(signed'(c_rdata));
                sat_next   = 1'b0;
                i_next     = CW'(1);
                state_next = ST_EV_CI;
            end
            ST_EV_CI: state_next = ST_EV_T;
            ST_EV_T:
            begin
                term_next  = c_rdata;
                u_next     = '0;
                state_next = ST_EV_X;
            end
            ST_EV_X: state_next = ST_EV_D;
            ST_EV_D:
            begin
                d_next     = dsat.val;
                sat_next   = sat_reg || dsat.clip;
                state_next = ST_EV_MUL;
            end
            ST_EV_MUL:
            begin
                prod_next  = 64'(mag32(term_reg)) * 64'(mag32(d_reg));
                neg_next   = term_reg[31] != d_reg[31];
                state_next = ST_EV_NRM;
            end
            ST_EV_NRM:
            begin
                term_next = fm.val;
                sat_next  = sat_reg || fm.clip;
                if (u_reg == i_reg - CW'(1))
                begin
                    acc_next = acc_reg + ACC_W'(fm.val);
                    if (i_reg == n_act - CW'(1))
                    begin
                        fin_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_EV_CI;
                    end
                end
                else
                begin
                    u_next     = u_reg + CW'(1);
                    state_next = ST_EV_X;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg_wr_en)
        begin
            pts_next   = cfg_wr_data;
            stale_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WORK;
            fin_reg       <= 1'b0;
            stale_reg     <= 1'b1;
            fault_reg     <= 1'b0;
            clip_reg      <= 1'b0;
            pts_reg       <= 5'd5;
            i_reg         <= '0;
            u_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            stale_reg     <= stale_next;
            fault_reg     <= fault_next;
            clip_reg      <= clip_next;
            pts_reg       <= pts_next;
            i_reg         <= i_next;
            u_reg         <= u_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg       <= qx_next;
        c_hi_reg     <= c_hi_next;
        x_hi_reg     <= x_hi_next;
        term_reg     <= term_next;
        d_reg        <= d_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        sat_reg      <= sat_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        rsp_val_reg  <= rsp_val_next;
        rsp_stat_reg <= rsp_stat_next;
    end

    // node x, node y and coefficient tables
    ndd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_node_x (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (req.x_value),
        .raddr (n_raddr),
        .rdata (x_rdata)
    );

    ndd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_node_y (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (req.y_value),
        .raddr (n_raddr),
        .rdata (y_rdata)
    );

    ndd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_coef (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    ndd_div #(.NUM_W(NUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

endmodule
